### hdl/irpd_pkg.sv
// Shared types and constants of the pulse-distance frame encoder.
package irpd_pkg;

  localparam int BitsPerByte = 8;
  localparam int NumRegs     = 8;
  localparam int CfgIdxW     = 4;
  localparam int DurW        = 16;
  localparam int QueueDepth  = 2;

  localparam logic [CfgIdxW-1:0] RegLeaderMark   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegLeaderSpace  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegTrailerMark  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegTrailerSpace = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegOneMark      = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegOneSpace     = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegZeroMark     = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegZeroSpace    = CfgIdxW'(7);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } irpd_in_t;

  typedef struct packed {
    logic            carrier_on;
    logic [DurW-1:0] duration_us;
    logic            last_segment;
  } irpd_out_t;

  typedef struct packed {
    logic [DurW-1:0] leader_mark_us;
    logic [DurW-1:0] leader_space_us;
    logic [DurW-1:0] trailer_mark_us;
    logic [DurW-1:0] trailer_space_us;
    logic [DurW-1:0] one_mark_us;
    logic [DurW-1:0] one_space_us;
    logic [DurW-1:0] zero_mark_us;
    logic [DurW-1:0] zero_space_us;
  } irpd_cfg_t;

endpackage

### hdl/ir_pulse_distance_frame_encoder_unit.sv
// Top level of the pulse-distance infrared frame encoder.
//
// Each input word carries one frame byte with first and last flags. The block
// answers with a run of segments (carrier on or off, duration in microseconds):
// a leader mark and space when the first flag is set, one mark and space per
// data bit LSB first, and a trailer mark and space when the last flag is set.
// A set bit takes the zero-bit timing and a clear bit the one-bit timing. The
// final segment of each run has last_segment set.
// Timing registers are written on the configuration channel, which is always
// ready; writes to an index past the last register are dropped.
// A word is written into the queue before its first segment is registered.
// The output register sets the rate: segments leave one per cycle while the
// receiver is ready, 2*BITS_PER_BYTE per word plus two for each flag set.
// A two-entry queue sits between input and sequencer, so new words are
// accepted while the receiver stalls until the queue is full.
// Reset clears all timing registers, the queue and the output register.
module ir_pulse_distance_frame_encoder_unit import irpd_pkg::*; #(
  parameter int BITS_PER_BYTE = BitsPerByte
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  irpd_in_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output irpd_out_t          out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DurW-1:0]    cfg_data_i
);

  irpd_cfg_t cfg;
  logic      head_valid, pop;
  irpd_in_t  head;

  assign cfg_ready_o = 1'b1;

  irpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  irpd_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  irpd_back #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

### hdl/irpd_cfg.sv
// Timing register file of the pulse-distance frame encoder.
module irpd_cfg import irpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DurW-1:0]    cfg_data_i,
  output irpd_cfg_t          cfg_o
);

  irpd_cfg_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLeaderMark:   regs_q.leader_mark_us   <= cfg_data_i;
        RegLeaderSpace:  regs_q.leader_space_us  <= cfg_data_i;
        RegTrailerMark:  regs_q.trailer_mark_us  <= cfg_data_i;
        RegTrailerSpace: regs_q.trailer_space_us <= cfg_data_i;
        RegOneMark:      regs_q.one_mark_us      <= cfg_data_i;
        RegOneSpace:     regs_q.one_space_us     <= cfg_data_i;
        RegZeroMark:     regs_q.zero_mark_us     <= cfg_data_i;
        RegZeroSpace:    regs_q.zero_space_us    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = regs_q;

endmodule

### hdl/irpd_front.sv
// Input side: accepts frame words into a short queue ahead of the sequencer.
module irpd_front import irpd_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  irpd_in_t in_word_i,
  output logic     head_valid_o,
  output irpd_in_t head_o,
  input  logic     pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  irpd_in_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

### hdl/irpd_back.sv
// Segment sequencer: walks leader, data bits and trailer of the head word.
module irpd_back import irpd_pkg::*; #(
  parameter int BITS_PER_BYTE = BitsPerByte
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  irpd_cfg_t cfg_i,
  input  logic      head_valid_i,
  input  irpd_in_t  head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output irpd_out_t out_word_o
);

  localparam int IdxW = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
  localparam int ExtW = (BITS_PER_BYTE > 8) ? BITS_PER_BYTE : 8;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BITS_PER_BYTE - 1);

  typedef enum logic [1:0] {
    PH_START,
    PH_LEADER,
    PH_DATA,
    PH_TRAILER
  } phase_e;

  phase_e          phase_q, phase_d, phase_eff;
  logic            space_q, space_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q;
  irpd_out_t       out_q;
  irpd_out_t       seg;
  logic [ExtW-1:0] ext_bits;
  logic            cur_bit, fire, final_seg;

  assign ext_bits = ExtW'(head_i.data_byte);
  assign cur_bit  = ext_bits[idx_q];
  assign fire     = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_eff = phase_q;
    if (phase_q == PH_START) begin
      phase_eff = head_i.first_byte ? PH_LEADER : PH_DATA;
    end
  end

  always_comb begin
    seg.carrier_on = !space_q;
    case (phase_eff)
      PH_LEADER: begin
        seg.duration_us = space_q ? cfg_i.leader_space_us : cfg_i.leader_mark_us;
      end
      PH_TRAILER: begin
        seg.duration_us = space_q ? cfg_i.trailer_space_us : cfg_i.trailer_mark_us;
      end
      default: begin
        if (cur_bit) begin
          seg.duration_us = space_q ? cfg_i.zero_space_us : cfg_i.zero_mark_us;
        end else begin
          seg.duration_us = space_q ? cfg_i.one_space_us : cfg_i.one_mark_us;
        end
      end
    endcase
    final_seg = space_q && ((phase_eff == PH_TRAILER) ||
                ((phase_eff == PH_DATA) && (idx_q == LastIdx) && !head_i.last_byte));
    seg.last_segment = final_seg;
  end

  always_comb begin
    phase_d = phase_eff;
    idx_d   = idx_q;
    space_d = !space_q;
    if (space_q) begin
      case (phase_eff)
        PH_LEADER: begin
          phase_d = PH_DATA;
          idx_d   = '0;
        end
        PH_DATA: begin
          if (idx_q == LastIdx) begin
            phase_d = head_i.last_byte ? PH_TRAILER : PH_START;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          phase_d = PH_START;
          idx_d   = '0;
        end
      endcase
    end
  end

  assign pop_o = fire && final_seg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      space_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (fire) begin
        phase_q     <= phase_d;
        space_q     <= space_d;
        idx_q       <= idx_d;
        out_valid_q <= 1'b1;
        out_q       <= seg;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_mid_run_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_START || space_q) |-> head_valid_i)
    else $error("sequencer is mid-run without a queued word");

  a_run_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (phase_q == PH_START) && !space_q && (idx_q == '0))
    else $error("sequencer state not cleared after the final segment");

  a_space_after_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (space_q && out_valid_q) |-> out_q.carrier_on)
    else $error("space pending but the held segment is not a mark");

endmodule

### dv/irpd_checker.sv
// Checker that predicts and compares the segment runs of the pulse-distance encoder.
module irpd_checker import irpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  irpd_in_t           in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  irpd_out_t          out_word_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DurW-1:0]    cfg_data_i,
  output int                 error_count_o,
  output int                 pending_o,
  output int                 bytes_o,
  output int                 segments_o
);
  timeunit 1ns;
  timeprecision 1ps;

  irpd_cfg_t timing;
  irpd_out_t expected_segments[$];
  int        errors;
  int        byte_total;
  int        segment_total;

  function automatic void set_timing(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
    case (idx)
      RegLeaderMark:   timing.leader_mark_us   = val;
      RegLeaderSpace:  timing.leader_space_us  = val;
      RegTrailerMark:  timing.trailer_mark_us  = val;
      RegTrailerSpace: timing.trailer_space_us = val;
      RegOneMark:      timing.one_mark_us      = val;
      RegOneSpace:     timing.one_space_us     = val;
      RegZeroMark:     timing.zero_mark_us     = val;
      RegZeroSpace:    timing.zero_space_us    = val;
      default: ;
    endcase
  endfunction

  function automatic void encode_byte(irpd_in_t w);
    irpd_out_t run[$];
    logic      bit_set;
    if (w.first_byte) begin
      run.push_back('{carrier_on: 1'b1, duration_us: timing.leader_mark_us, last_segment: 1'b0});
      run.push_back('{carrier_on: 1'b0, duration_us: timing.leader_space_us, last_segment: 1'b0});
    end
    for (int b = 0; b < BitsPerByte; b++) begin
      bit_set = (b < 8) ? w.data_byte[b] : 1'b0;
      if (bit_set) begin
        run.push_back('{carrier_on: 1'b1, duration_us: timing.zero_mark_us, last_segment: 1'b0});
        run.push_back('{carrier_on: 1'b0, duration_us: timing.zero_space_us, last_segment: 1'b0});
      end else begin
        run.push_back('{carrier_on: 1'b1, duration_us: timing.one_mark_us, last_segment: 1'b0});
        run.push_back('{carrier_on: 1'b0, duration_us: timing.one_space_us, last_segment: 1'b0});
      end
    end
    if (w.last_byte) begin
      run.push_back('{carrier_on: 1'b1, duration_us: timing.trailer_mark_us, last_segment: 1'b0});
      run.push_back('{carrier_on: 1'b0, duration_us: timing.trailer_space_us, last_segment: 1'b0});
    end
    run[run.size()-1].last_segment = 1'b1;
    foreach (run[k]) expected_segments.push_back(run[k]);
  endfunction

  function automatic void check_segment(irpd_out_t got);
    irpd_out_t want;
    if (expected_segments.size() == 0) begin
      $error("Segment word with nothing expected: carrier_on=%0d duration_us=%0d last=%0d",
             got.carrier_on, got.duration_us, got.last_segment);
      errors++;
      return;
    end
    want = expected_segments.pop_front();
    if (got.carrier_on !== want.carrier_on) begin
      $error("carrier_on expected %0d actual %0d", want.carrier_on, got.carrier_on);
      errors++;
    end
    if (got.duration_us !== want.duration_us) begin
      $error("duration_us expected %0d actual %0d", want.duration_us, got.duration_us);
      errors++;
    end
    if (got.last_segment !== want.last_segment) begin
      $error("last_segment expected %0d actual %0d", want.last_segment, got.last_segment);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing = '0;
      expected_segments.delete();
      errors = 0;
      byte_total = 0;
      segment_total = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) set_timing(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        encode_byte(in_word_i);
        byte_total++;
      end
      if (out_valid_i && out_ready_i) begin
        check_segment(out_word_i);
        segment_total++;
      end
    end
    error_count_o <= errors;
    pending_o     <= expected_segments.size();
    bytes_o       <= byte_total;
    segments_o    <= segment_total;
  end

endmodule

### dv/tb_ir_pulse_distance_frame_encoder_unit.sv
// Testbench top that drives the pulse-distance encoder and reports the verdict.
module tb_ir_pulse_distance_frame_encoder_unit;
  import irpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit   = 4000;
  localparam int DrainCycles  = 30;
  localparam int RandomPhases = 5;
  localparam int BytesPerPhase = 50;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  irpd_in_t           in_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  irpd_out_t          out_word_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DurW-1:0]    cfg_data_i;

  int   error_count;
  int   pending;
  int   bytes_seen;
  int   segments_seen;
  int   settings_used;
  int   idle_cycles;
  int   ready_hold;
  logic calm;

  ir_pulse_distance_frame_encoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  irpd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_word_i     (in_word_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_i    (out_word_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .error_count_o (error_count),
    .pending_o     (pending),
    .bytes_o       (bytes_seen),
    .segments_o    (segments_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DurW-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DurW'($urandom_range(0, 65535));
  endfunction

  initial begin
    out_ready_i = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk_i);
      if (ready_hold != 0) begin
        ready_hold--;
      end else if (out_ready_i && !calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        ready_hold = pick_gap();
      end else begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("Watchdog: no word moved for %0d cycles.", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{data_byte: data, first_byte: first, last_byte: last};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_timing(input irpd_cfg_t t);
    put_reg(CfgIdxW'($urandom_range(NumRegs, 15)), DurW'($urandom_range(0, 65535)));
    put_reg(RegLeaderMark,   t.leader_mark_us);
    put_reg(RegLeaderSpace,  t.leader_space_us);
    put_reg(RegTrailerMark,  t.trailer_mark_us);
    put_reg(RegTrailerSpace, t.trailer_space_us);
    put_reg(RegOneMark,      t.one_mark_us);
    put_reg(RegOneSpace,     t.one_space_us);
    put_reg(RegZeroMark,     t.zero_mark_us);
    put_reg(RegZeroSpace,    t.zero_space_us);
    put_reg(CfgIdxW'($urandom_range(NumRegs, 15)), DurW'($urandom_range(0, 65535)));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    irpd_cfg_t   t;
    logic [7:0]  patterns[6];
    int          sent;
    int          len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    calm        = 1'b0;
    settings_used = 1;
    patterns = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // All timing registers are still zero, so every segment has zero length.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b1, 1'b1);
    wait_idle();

    t = '{16'd9000, 16'd4500, 16'd560, 16'd40000, 16'd560, 16'd1690, 16'd560, 16'd560};
    load_timing(t);
    foreach (patterns[k]) send_byte(patterns[k], k[0], k[1]);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h3C, 1'b0, 1'b0);
    wait_idle();

    t = '1;
    load_timing(t);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    wait_idle();

    t = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
    load_timing(t);
    send_byte(8'h0F, 1'b1, 1'b1);
    send_byte(8'hF0, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      t = '{pick_duration(), pick_duration(), pick_duration(), pick_duration(),
            pick_duration(), pick_duration(), pick_duration(), pick_duration()};
      load_timing(t);
      calm = (p == 2);
      sent = 0;
      while (sent < BytesPerPhase) begin
        if ($urandom_range(0, 9) < 8) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == 0, k == len - 1);
          end
          sent += len;
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end
      end
      calm = 1'b0;
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d bytes and %0d segments over %0d timing settings,",
             bytes_seen, segments_seen, settings_used);
    $display("with zero and full-scale durations and writes to unused register slots.");
    if (error_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/irpd_pkg.sv
hdl/irpd_cfg.sv
hdl/irpd_front.sv
hdl/irpd_back.sv
hdl/ir_pulse_distance_frame_encoder_unit.sv
dv/irpd_checker.sv
dv/tb_ir_pulse_distance_frame_encoder_unit.sv
